>>> hw/rtl/satm_pkg.sv
// ----------------------------------------------------------------------------
// satm_pkg
// Shared types and constants of the set-associative cache tag model unit.
// ----------------------------------------------------------------------------
package satm_pkg;

  // Default geometry handed to the top level parameters.
  localparam int NumSetsDef = 16;
  localparam int NumWaysDef = 4;

  // Address width of the modeled machine; address_bits above it is clipped.
  localparam int AddrWidthC = 32;

  // Widths of the request and result fields.
  localparam int AddrW  = 32;
  localparam int TagW   = 32;
  localparam int CountW = 16;
  localparam int StampW = 32;
  localparam int TotalW = 32;
  localparam int CycleW = 48;

  // Widths of the configuration registers.
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 10;
  localparam int WaysCfgW  = 3;
  localparam int OffCfgW   = 4;
  localparam int IdxCfgW   = 3;
  localparam int AbitCfgW  = 6;
  localparam int HitTimeW  = 8;
  localparam int PenaltyW  = 10;

  // Width of the raw set index before it is folded into the set range.
  localparam int RawSetW = (1 << IdxCfgW) - 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPolicyLfu   = 3'd0,
    CfgWaysInUse   = 3'd1,
    CfgOffsetBits  = 3'd2,
    CfgIndexBits   = 3'd3,
    CfgAddressBits = 3'd4,
    CfgHitTime     = 3'd5,
    CfgMissPenalty = 3'd6
  } satm_cfg_idx_e;

  // One way of a set row as held in the line memory.
  typedef struct packed {
    logic              valid;
    logic [TagW-1:0]   tag;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } satm_line_t;

endpackage

>>> hw/rtl/satm_ram.sv
// ----------------------------------------------------------------------------
// satm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module satm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/satm_decode.sv
// ----------------------------------------------------------------------------
// satm_decode
// Split a request address into set index and tag under the current config.
// ----------------------------------------------------------------------------
module satm_decode #(
  parameter int NUM_SETS = satm_pkg::NumSetsDef,
  localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic [satm_pkg::AddrW-1:0]    addr_i,
  input  logic [satm_pkg::OffCfgW-1:0]  offset_bits_i,
  input  logic [satm_pkg::IdxCfgW-1:0]  index_bits_i,
  input  logic [satm_pkg::AbitCfgW-1:0] address_bits_i,
  output logic [SetW-1:0]               set_o,
  output logic [satm_pkg::TagW-1:0]     tag_o
);

  import satm_pkg::*;

  logic [AddrW-1:0]   masked;
  logic [AddrW-1:0]   shifted;
  logic [RawSetW-1:0] raw_set;
  logic [4:0]         tag_shift;
  logic [31:0]        rem;

  // Drop address bits at and above the active address width.
  always_comb begin
    for (int j = 0; j < AddrW; j++) begin
      masked[j] = addr_i[j] & (AbitCfgW'(j) < address_bits_i) & (j < AddrWidthC);
    end
  end

  assign shifted   = masked >> offset_bits_i;
  assign raw_set   = shifted[RawSetW-1:0] & ~({RawSetW{1'b1}} << index_bits_i);
  assign tag_shift = 5'(offset_bits_i) + 5'(index_bits_i);
  assign tag_o     = TagW'(masked >> tag_shift);

  // Fold the raw set into range: restoring reduction, one shifted set count per step.
  always_comb begin
    rem = 32'(raw_set);
    for (int k = RawSetW - 1; k >= 0; k--) begin
      if (rem >= 32'(NUM_SETS << k)) begin
        rem = rem - 32'(NUM_SETS << k);
      end
    end
  end

  assign set_o = SetW'(rem);

endmodule

>>> hw/rtl/satm_select.sv
// ----------------------------------------------------------------------------
// satm_select
// Pick the way of a set row: the hit way, else the first free way, else the
// LRU or LFU victim through a compare tree.
// ----------------------------------------------------------------------------
module satm_select #(
  parameter int NUM_WAYS = satm_pkg::NumWaysDef,
  localparam int WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  satm_pkg::satm_line_t [NUM_WAYS-1:0] row_i,
  input  logic [satm_pkg::TagW-1:0]            tag_i,
  input  logic [satm_pkg::WaysCfgW-1:0]        ways_in_use_i,
  input  logic                                 policy_lfu_i,
  output logic                                 hit_o,
  output logic [WayW-1:0]                      way_o
);

  import satm_pkg::*;

  localparam int TreeN = 1 << $clog2(NUM_WAYS);

  logic [NUM_WAYS-1:0] in_use;
  logic                hit_any;
  logic [WayW-1:0]     hit_way;
  logic                free_any;
  logic [WayW-1:0]     free_way;
  logic                node_en  [1:2*TreeN-1];
  logic [StampW-1:0]   node_key [1:2*TreeN-1];
  logic [WayW-1:0]     node_idx [1:2*TreeN-1];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      in_use[w] = (w == 0) || (32'(w) < 32'(ways_in_use_i));
    end
  end

  // Lowest matching way and lowest free way: scan downward so the lowest wins.
  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row_i[w].valid && (row_i[w].tag == tag_i)) begin
        hit_any = 1'b1;
        hit_way = WayW'(w);
      end
      if (in_use[w] && !row_i[w].valid) begin
        free_any = 1'b1;
        free_way = WayW'(w);
      end
    end
  end

  // Minimum tree; the lower-numbered side wins ties.
  always_comb begin
    for (int w = 0; w < TreeN; w++) begin
      if (w < NUM_WAYS) begin
        node_en[TreeN+w]  = in_use[w];
        node_key[TreeN+w] = policy_lfu_i ? StampW'(row_i[w].count) : row_i[w].stamp;
        node_idx[TreeN+w] = WayW'(w);
      end else begin
        node_en[TreeN+w]  = 1'b0;
        node_key[TreeN+w] = '0;
        node_idx[TreeN+w] = '0;
      end
    end
    for (int i = TreeN - 1; i >= 1; i--) begin
      if (node_en[2*i] && (!node_en[2*i+1] || (node_key[2*i] <= node_key[2*i+1]))) begin
        node_en[i]  = 1'b1;
        node_key[i] = node_key[2*i];
        node_idx[i] = node_idx[2*i];
      end else begin
        node_en[i]  = node_en[2*i+1];
        node_key[i] = node_key[2*i+1];
        node_idx[i] = node_idx[2*i+1];
      end
    end
  end

  assign hit_o = hit_any;

  always_comb begin
    priority if (hit_any) begin
      way_o = hit_way;
    end else if (free_any) begin
      way_o = free_way;
    end else begin
      way_o = node_idx[1];
    end
  end

endmodule

>>> hw/rtl/set_assoc_cache_tag_model_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model_unit
// Set-associative cache tag model with LRU or LFU replacement and running
// hit, miss and cycle totals.
// ----------------------------------------------------------------------------
// Each request carries one byte address. The unit splits it into set and tag,
// looks the tag up in the set, updates or replaces a way, and returns one
// result: hit flag plus saturating hit, miss and cycle totals. The result is
// shown for exactly one cycle with done_o high, registered from the write-back
// state; the receiver cannot stall it and must take it then. Each request
// reads the set row from the line memory, picks a way, and writes the row back,
// and that write-back state already takes the next request, before the last
// result is shown. busy is high otherwise. After reset a clearing pass writes
// every set row once with busy held high; config writes are taken at any time
// but must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_model_unit #(
  parameter int NUM_SETS = satm_pkg::NumSetsDef,
  parameter int NUM_WAYS = satm_pkg::NumWaysDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic [satm_pkg::AddrW-1:0]      address_i,
  // config
  input  logic                            cfg_we_i,
  input  logic [satm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [satm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // result
  output logic                            done_o,
  output logic                            hit_o,
  output logic [satm_pkg::TotalW-1:0]     hit_total_o,
  output logic [satm_pkg::TotalW-1:0]     miss_total_o,
  output logic [satm_pkg::CycleW-1:0]     cycle_total_o
);

  import satm_pkg::*;

  localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RowW = NUM_WAYS * $bits(satm_line_t);
  localparam int AmtW = PenaltyW + 1;

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StRead   = 5'b00100,
    StSelect = 5'b01000,
    StWrite  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic                policy_lfu_q;
  logic [WaysCfgW-1:0] ways_in_use_q;
  logic [OffCfgW-1:0]  offset_bits_q;
  logic [IdxCfgW-1:0]  index_bits_q;
  logic [AbitCfgW-1:0] address_bits_q;
  logic [HitTimeW-1:0] hit_time_q;
  logic [PenaltyW-1:0] miss_penalty_q;

  // per-request pipeline
  logic [AddrW-1:0] addr_q;
  logic [SetW-1:0]  set_q;
  logic [TagW-1:0]  tag_q;
  logic             sel_hit_q;
  logic [WayW-1:0]  way_q;
  logic [SetW-1:0]  clr_q;

  // running state and result
  logic [StampW-1:0] stamp_q;
  logic [TotalW-1:0] hit_cnt_q;
  logic [TotalW-1:0] miss_cnt_q;
  logic [CycleW-1:0] cyc_q;
  logic              done_q;
  logic              hit_q;

  logic                          accept;
  logic [SetW-1:0]               dec_set;
  logic [TagW-1:0]               dec_tag;
  logic                          sel_hit;
  logic [WayW-1:0]               sel_way;
  logic [RowW-1:0]               rdata;
  satm_line_t [NUM_WAYS-1:0]     rd_row;
  satm_line_t [NUM_WAYS-1:0]     wr_row;
  logic                          ram_we;
  logic [SetW-1:0]               ram_waddr;
  logic [RowW-1:0]               ram_wdata;
  logic [StampW-1:0]             stamp_next;
  logic [AmtW-1:0]               amount;
  logic [CycleW:0]               cyc_sum;

  // A request can enter while idle and in the write-back cycle.
  assign busy   = !((state_q == StIdle) || (state_q == StWrite));
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == SetW'(NUM_SETS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          state_d = StRead;
        end
      end
      StRead:   state_d = StSelect;
      StSelect: state_d = StWrite;
      StWrite: begin
        state_d = start ? StRead : StIdle;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + SetW'(1);
      end
    end
  end

  // Config writes; codes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_lfu_q   <= 1'b0;
      ways_in_use_q  <= WaysCfgW'(4);
      offset_bits_q  <= OffCfgW'(4);
      index_bits_q   <= IdxCfgW'(4);
      address_bits_q <= AbitCfgW'(32);
      hit_time_q     <= HitTimeW'(1);
      miss_penalty_q <= PenaltyW'(100);
    end else if (cfg_we_i) begin
      unique case (satm_cfg_idx_e'(cfg_idx_i))
        CfgPolicyLfu:   policy_lfu_q   <= cfg_wdata_i[0];
        CfgWaysInUse:   ways_in_use_q  <= cfg_wdata_i[WaysCfgW-1:0];
        CfgOffsetBits:  offset_bits_q  <= cfg_wdata_i[OffCfgW-1:0];
        CfgIndexBits:   index_bits_q   <= cfg_wdata_i[IdxCfgW-1:0];
        CfgAddressBits: address_bits_q <= cfg_wdata_i[AbitCfgW-1:0];
        CfgHitTime:     hit_time_q     <= cfg_wdata_i[HitTimeW-1:0];
        CfgMissPenalty: miss_penalty_q <= cfg_wdata_i[PenaltyW-1:0];
        default: ;
      endcase
    end
  end

  satm_decode #(
    .NUM_SETS(NUM_SETS)
  ) u_decode (
    .addr_i        (addr_q),
    .offset_bits_i (offset_bits_q),
    .index_bits_i  (index_bits_q),
    .address_bits_i(address_bits_q),
    .set_o         (dec_set),
    .tag_o         (dec_tag)
  );

  // Line memory: one row per set, all ways side by side.
  satm_ram #(
    .WIDTH(RowW),
    .DEPTH(NUM_SETS)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (state_q == StRead),
    .raddr_i(dec_set),
    .rdata_o(rdata)
  );

  assign rd_row = rdata;

  satm_select #(
    .NUM_WAYS(NUM_WAYS)
  ) u_select (
    .row_i        (rd_row),
    .tag_i        (tag_q),
    .ways_in_use_i(ways_in_use_q),
    .policy_lfu_i (policy_lfu_q),
    .hit_o        (sel_hit),
    .way_o        (sel_way)
  );

  // Every access, hit or fill, takes the next stamp.
  assign stamp_next = stamp_q + StampW'(1);

  // Rebuild the row: refresh the chosen way, keep the others.
  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WayW'(w) == way_q) begin
        wr_row[w].valid = 1'b1;
        wr_row[w].tag   = tag_q;
        wr_row[w].stamp = stamp_next;
        if (sel_hit_q) begin
          wr_row[w].count = (rd_row[w].count == '1) ? rd_row[w].count
                                                    : rd_row[w].count + CountW'(1);
        end else begin
          wr_row[w].count = '0;
        end
      end
    end
  end

  // The clearing pass zeroes each row, which leaves every way invalid.
  assign ram_we    = (state_q == StClear) || (state_q == StWrite);
  assign ram_waddr = (state_q == StClear) ? clr_q : set_q;
  assign ram_wdata = (state_q == StClear) ? '0 : RowW'(wr_row);

  // Cycle cost of this request, then a saturating add into the 48-bit total.
  assign amount  = AmtW'(hit_time_q) + (sel_hit_q ? AmtW'(0) : AmtW'(miss_penalty_q));
  assign cyc_sum = {1'b0, cyc_q} + (CycleW + 1)'(amount);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= address_i;
    end
    if (state_q == StRead) begin
      set_q <= dec_set;
      tag_q <= dec_tag;
    end
    if (state_q == StSelect) begin
      sel_hit_q <= sel_hit;
      way_q     <= sel_way;
    end
    if (state_q == StWrite) begin
      hit_q <= sel_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      cyc_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= (state_q == StWrite);
      if (state_q == StWrite) begin
        stamp_q <= stamp_next;
        if (sel_hit_q) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + TotalW'(1);
          end
        end else begin
          if (miss_cnt_q != '1) begin
            miss_cnt_q <= miss_cnt_q + TotalW'(1);
          end
        end
        // Clamp at all ones once the total would reach or pass it.
        if (cyc_sum >= (CycleW + 1)'({CycleW{1'b1}})) begin
          cyc_q <= '1;
        end else begin
          cyc_q <= cyc_sum[CycleW-1:0];
        end
      end
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign cycle_total_o = cyc_q;

endmodule

>>> test/tb_set_assoc_cache_tag_model_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_model_unit
// Self-checking bench for the set-associative cache tag model unit.
// ----------------------------------------------------------------------------
// A plan of lookups, register writes, drain points and pacing changes is built
// at time zero. A clocked driver walks the plan, issues each lookup over the
// start/busy handshake and runs a shadow cache (tags, use counts, recency
// stamps, running totals) to predict every result. A clocked monitor compares
// each done_o strobe field by field against the oldest prediction. Coverage
// comes from a short directed pass (cold fills, LRU and LFU eviction, victim
// ties, clipped and folded geometry, ignored register index), an LFU run with
// unequal use counts, and random phases with random geometry, costs and
// sender pacing.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_model_unit;
  import satm_pkg::*;

  localparam int NumLines      = NumSetsDef * NumWaysDef;
  localparam int DrainHold     = 6;
  localparam int WatchdogLimit = 2000;
  localparam int ReportCap     = 40;
  localparam int IdleNone      = 0;
  localparam int IdleHeavy     = 88;
  localparam int IdleLight     = 17;
  localparam logic [CfgIdxW-1:0]  CfgIdxUnused = 3'd7;
  localparam logic [CycleW-1:0]   CycleCeil    = '1;

  typedef enum logic [1:0] {
    StepLookup,
    StepRegWrite,
    StepDrain,
    StepPace
  } plan_kind_e;

  typedef struct {
    plan_kind_e             kind;
    logic [AddrW-1:0]       addr;
    logic [CfgIdxW-1:0]     reg_idx;
    logic [CfgDataW-1:0]    reg_data;
    int unsigned            idle_pct;
  } plan_step_t;

  typedef struct packed {
    logic              hit;
    logic [TotalW-1:0] hits;
    logic [TotalW-1:0] misses;
    logic [CycleW-1:0] cycles;
  } lookup_result_t;

  // DUT connections; every input starts at a known value
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [AddrW-1:0]    address_i   = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [TotalW-1:0]   hit_total_o;
  logic [TotalW-1:0]   miss_total_o;
  logic [CycleW-1:0]   cycle_total_o;

  // Stimulus plan and predictions waiting for their strobe
  plan_step_t     req_plan[$];
  lookup_result_t pending_lookups[$];

  // Shadow register file, loaded with the reset values
  logic                pol_lfu       = 1'b0;
  logic [WaysCfgW-1:0] ways_cfg      = 3'd4;
  logic [OffCfgW-1:0]  off_cfg       = 4'd4;
  logic [IdxCfgW-1:0]  idx_cfg       = 3'd4;
  logic [AbitCfgW-1:0] abits_cfg     = 6'd32;
  logic [HitTimeW-1:0] hit_cost_cfg  = 8'd1;
  logic [PenaltyW-1:0] miss_cost_cfg = 10'd100;

  // Shadow cache contents and running totals
  logic              way_valid [NumLines];
  logic [TagW-1:0]   way_tag   [NumLines];
  logic [CountW-1:0] way_uses  [NumLines];
  logic [StampW-1:0] way_age   [NumLines];
  logic [StampW-1:0] access_seq    = '0;
  logic [TotalW-1:0] hits_so_far   = '0;
  logic [TotalW-1:0] misses_so_far = '0;
  logic [CycleW-1:0] cost_so_far   = '0;

  // Geometry as the plan builder last set it, used to aim addresses
  int unsigned gen_off   = 4;
  int unsigned gen_idx   = 4;
  int unsigned gen_abits = 32;

  int unsigned sender_idle_pct = IdleNone;
  int unsigned hold_left       = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned result_no       = 0;
  int unsigned error_count     = 0;

  set_assoc_cache_tag_model_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .address_i    (address_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .cycle_total_o(cycle_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NumLines; i++) way_valid[i] = 1'b0;
  end

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic report_mismatch(string what);
    if (error_count < ReportCap) $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  // Load one register into the shadow copy; drop writes to unused indexes.
  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgPolicyLfu:   pol_lfu       = data[0];
      CfgWaysInUse:   ways_cfg      = data[WaysCfgW-1:0];
      CfgOffsetBits:  off_cfg       = data[OffCfgW-1:0];
      CfgIndexBits:   idx_cfg       = data[IdxCfgW-1:0];
      CfgAddressBits: abits_cfg     = data[AbitCfgW-1:0];
      CfgHitTime:     hit_cost_cfg  = data[HitTimeW-1:0];
      CfgMissPenalty: miss_cost_cfg = data[PenaltyW-1:0];
      default: ;
    endcase
  endtask

  // Run one lookup through the shadow cache and return the result it owes.
  function automatic lookup_result_t predict_lookup(logic [AddrW-1:0] req_addr);
    lookup_result_t   res;
    int unsigned      abits;
    int unsigned      ways;
    int unsigned      set_idx;
    int unsigned      base;
    int unsigned      victim;
    int unsigned      w;
    logic [63:0]      keep_mask;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] raw_set;
    logic [TagW-1:0]  tag;
    logic             hit_found;
    logic             free_found;
    logic [CycleW-1:0] charge;

    // Clip the address width and the way count to what the unit holds
    abits = (abits_cfg > AddrWidthC) ? AddrWidthC : abits_cfg;
    ways  = (ways_cfg == 0) ? 1 : ((ways_cfg > NumWaysDef) ? NumWaysDef : ways_cfg);
    keep_mask = (64'd1 << abits) - 64'd1;
    addr      = req_addr & keep_mask[AddrW-1:0];
    // Fold set indexes beyond the set range; a tag past the top reads as zero
    raw_set = (addr >> off_cfg) & ((32'd1 << idx_cfg) - 32'd1);
    set_idx = raw_set % NumSetsDef;
    tag     = addr >> (32'(off_cfg) + 32'(idx_cfg));
    base    = set_idx * NumWaysDef;

    hit_found  = 1'b0;
    free_found = 1'b0;
    victim     = base;
    for (w = 0; w < ways; w++) begin
      if (!hit_found && way_valid[base+w] && way_tag[base+w] == tag) begin
        hit_found = 1'b1;
        if (way_uses[base+w] != '1) way_uses[base+w]++;
        access_seq++;
        way_age[base+w] = access_seq;
      end
    end

    if (!hit_found) begin
      // Take the first empty way; otherwise the oldest or least used way,
      // the lowest way winning a tie
      for (w = 0; w < ways; w++) begin
        if (!free_found && !way_valid[base+w]) begin
          victim     = base + w;
          free_found = 1'b1;
        end
      end
      if (!free_found) begin
        for (w = 1; w < ways; w++) begin
          if (pol_lfu) begin
            if (way_uses[base+w] < way_uses[victim]) victim = base + w;
          end else begin
            if (way_age[base+w] < way_age[victim]) victim = base + w;
          end
        end
      end
      way_valid[victim] = 1'b1;
      way_tag[victim]   = tag;
      way_uses[victim]  = '0;
      access_seq++;
      way_age[victim]   = access_seq;
    end

    if (hit_found) begin
      if (hits_so_far != '1) hits_so_far++;
      charge = hit_cost_cfg;
    end else begin
      if (misses_so_far != '1) misses_so_far++;
      charge = hit_cost_cfg + miss_cost_cfg;
    end
    if (charge >= CycleCeil - cost_so_far) cost_so_far = CycleCeil;
    else cost_so_far = cost_so_far + charge;

    res.hit    = hit_found;
    res.hits   = hits_so_far;
    res.misses = misses_so_far;
    res.cycles = cost_so_far;
    return res;
  endfunction

  // Build an address for a tag and set under the planned geometry, with a
  // random block offset and random bits above the address width.
  function automatic logic [AddrW-1:0] compose_addr(logic [31:0] tag, logic [31:0] set_sel);
    int unsigned abits;
    logic [63:0] keep;
    logic [63:0] a;
    abits = (gen_abits > AddrWidthC) ? AddrWidthC : gen_abits;
    keep  = (64'd1 << abits) - 64'd1;
    a = ({32'd0, tag} << (gen_off + gen_idx))
      | (({32'd0, set_sel} & ((64'd1 << gen_idx) - 64'd1)) << gen_off)
      | ({32'd0, $urandom} & ((64'd1 << gen_off) - 64'd1));
    a = (a & keep) | ({32'd0, $urandom} & ~keep);
    return a[AddrW-1:0];
  endfunction

  task automatic push_lookup(logic [AddrW-1:0] addr);
    plan_step_t s;
    s.kind = StepLookup;
    s.addr = addr;
    req_plan.push_back(s);
  endtask

  // Hold the sender until every pending result has come back.
  task automatic push_drain();
    plan_step_t s;
    s.kind = StepDrain;
    req_plan.push_back(s);
  endtask

  task automatic push_pace(int unsigned pct);
    plan_step_t s;
    s.kind     = StepPace;
    s.idle_pct = pct;
    req_plan.push_back(s);
  endtask

  // Drain, then write one register; fill the bits above its width with junk.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val, int unsigned width);
    plan_step_t  s;
    logic [63:0] junk;
    junk = {32'd0, $urandom} << width;
    push_drain();
    s.kind     = StepRegWrite;
    s.reg_idx  = idx;
    s.reg_data = CfgDataW'(junk | val);
    req_plan.push_back(s);
    case (idx)
      CfgOffsetBits:  gen_off   = val;
      CfgIndexBits:   gen_idx   = val;
      CfgAddressBits: gen_abits = val;
      default: ;
    endcase
  endtask

  // Driver: walk the plan, one action per free cycle; predict each request at
  // the edge that accepts it; count quiet cycles for the watchdog.
  always @(posedge clk_i) begin
    logic                nxt_start;
    logic [AddrW-1:0]    nxt_addr;
    logic                nxt_we;
    logic [CfgIdxW-1:0]  nxt_idx;
    logic [CfgDataW-1:0] nxt_data;
    logic                took_req;
    if (rst_ni) begin
      nxt_start = start;
      nxt_addr  = address_i;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_idx_i;
      nxt_data  = cfg_wdata_i;
      took_req  = start && !busy;
      if (took_req) begin
        pending_lookups.push_back(predict_lookup(address_i));
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (hold_left != 0) begin
          hold_left--;
        end else if (req_plan.size() != 0) begin
          case (req_plan[0].kind)
            StepLookup: begin
              // Roll the idle dice each free cycle so gaps land anywhere
              if ($urandom_range(99) >= sender_idle_pct) begin
                nxt_start = 1'b1;
                nxt_addr  = req_plan[0].addr;
                void'(req_plan.pop_front());
              end
            end
            StepRegWrite: begin
              nxt_we   = 1'b1;
              nxt_idx  = req_plan[0].reg_idx;
              nxt_data = req_plan[0].reg_data;
              apply_reg(req_plan[0].reg_idx, req_plan[0].reg_data);
              void'(req_plan.pop_front());
            end
            StepDrain: begin
              // Wait out the last result, then let the write-back settle
              if (pending_lookups.size() == 0) begin
                hold_left = DrainHold;
                void'(req_plan.pop_front());
              end
            end
            StepPace: begin
              sender_idle_pct = req_plan[0].idle_pct;
              void'(req_plan.pop_front());
            end
            default: void'(req_plan.pop_front());
          endcase
        end
      end
      start       <= nxt_start;
      address_i   <= nxt_addr;
      cfg_we_i    <= nxt_we;
      cfg_idx_i   <= nxt_idx;
      cfg_wdata_i <= nxt_data;
      if (took_req || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL set_assoc_cache_tag_model_unit");
        $finish;
      end
    end
  end

  // Monitor: match every strobe against the oldest prediction.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && done_o) begin
      result_no++;
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request pending", result_no));
      end else begin
        want = pending_lookups.pop_front();
        if (hit_o !== want.hit)
          report_mismatch($sformatf("result %0d hit %b, want %b", result_no, hit_o, want.hit));
        if (hit_total_o !== want.hits)
          report_mismatch($sformatf("result %0d hit_total %0d, want %0d",
                                    result_no, hit_total_o, want.hits));
        if (miss_total_o !== want.misses)
          report_mismatch($sformatf("result %0d miss_total %0d, want %0d",
                                    result_no, miss_total_o, want.misses));
        if (cycle_total_o !== want.cycles)
          report_mismatch($sformatf("result %0d cycle_total %0d, want %0d",
                                    result_no, cycle_total_o, want.cycles));
      end
    end
  end

  initial begin
    logic [31:0] pool_tag[6];
    logic [31:0] pool_set[3];
    int unsigned n_tags;
    int unsigned n_sets;
    int unsigned pace_by_phase[3];
    int unsigned off_pick;
    int unsigned idx_pick;

    pace_by_phase[0] = IdleNone;
    pace_by_phase[1] = IdleHeavy;
    pace_by_phase[2] = IdleLight;

    // Reset geometry, LRU: cold miss, hit, top set, fill set 0, then evict
    // the oldest way after refreshing tag 0
    push_lookup(32'h0000_0000);
    push_lookup(32'h0000_0000);
    push_lookup(32'hFFFF_FFFF);
    push_lookup(compose_addr(1, 0));
    push_lookup(compose_addr(2, 0));
    push_lookup(compose_addr(3, 0));
    push_lookup(compose_addr(0, 0));
    push_lookup(compose_addr(4, 0));
    push_lookup(compose_addr(1, 0));

    // LFU over two ways: evict the less used way, then break a tie of
    // fresh lines toward way 0
    write_reg(CfgPolicyLfu, 1, 1);
    write_reg(CfgWaysInUse, 2, WaysCfgW);
    push_lookup(compose_addr(10, 1));
    push_lookup(compose_addr(11, 1));
    push_lookup(compose_addr(10, 1));
    push_lookup(compose_addr(12, 1));
    push_lookup(compose_addr(20, 2));
    push_lookup(compose_addr(21, 2));
    push_lookup(compose_addr(22, 2));
    push_lookup(compose_addr(21, 2));

    // Writes to the unused index must change nothing; zero ways acts as one
    write_reg(CfgIdxUnused, 0, 0);
    write_reg(CfgPolicyLfu, 0, 1);
    write_reg(CfgWaysInUse, 0, WaysCfgW);
    push_lookup(compose_addr(30, 3));
    push_lookup(compose_addr(31, 3));
    push_lookup(compose_addr(30, 3));

    // Oversized ways and address width, wide offset, set index folded mod 16,
    // top costs
    write_reg(CfgWaysInUse, 7, WaysCfgW);
    write_reg(CfgOffsetBits, 15, OffCfgW);
    write_reg(CfgIndexBits, 7, IdxCfgW);
    write_reg(CfgAddressBits, 63, AbitCfgW);
    write_reg(CfgHitTime, 255, HitTimeW);
    write_reg(CfgMissPenalty, 1023, PenaltyW);
    push_lookup(32'hFFFF_FFFF);
    push_lookup(32'h0000_0000);

    // Offset plus index past the address width: tag reads as zero
    write_reg(CfgAddressBits, 20, AbitCfgW);
    push_lookup($urandom);
    // Zero address width and zero costs: every address lands on one line
    write_reg(CfgAddressBits, 0, AbitCfgW);
    write_reg(CfgHitTime, 0, HitTimeW);
    write_reg(CfgMissPenalty, 0, PenaltyW);
    push_lookup($urandom);
    push_lookup($urandom);

    // Give one way a high use count and its neighbor a smaller one, and
    // check that LFU evicts the neighbor, not the busier way
    write_reg(CfgPolicyLfu, 1, 1);
    write_reg(CfgWaysInUse, 2, WaysCfgW);
    write_reg(CfgOffsetBits, 4, OffCfgW);
    write_reg(CfgIndexBits, 4, IdxCfgW);
    write_reg(CfgAddressBits, 32, AbitCfgW);
    write_reg(CfgHitTime, 1, HitTimeW);
    write_reg(CfgMissPenalty, 100, PenaltyW);
    push_lookup(compose_addr(40, 5));
    for (int k = 0; k < 20; k++) push_lookup(compose_addr(40, 5));
    push_lookup(compose_addr(41, 5));
    for (int k = 0; k < 10; k++) push_lookup(compose_addr(41, 5));
    push_lookup(compose_addr(42, 5));
    push_lookup(compose_addr(40, 5));

    // Random phases: random geometry and costs, a small pool of tags and
    // sets per phase so lines get reused and evicted, some raw noise
    for (int phase = 0; phase < 6; phase++) begin
      off_pick = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(15, 13);
      idx_pick = ($urandom_range(99) < 80) ? $urandom_range(4) : $urandom_range(7, 5);
      write_reg(CfgPolicyLfu, $urandom_range(1), 1);
      write_reg(CfgWaysInUse,
                ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(7),
                WaysCfgW);
      write_reg(CfgOffsetBits, off_pick, OffCfgW);
      write_reg(CfgIndexBits, idx_pick, IdxCfgW);
      write_reg(CfgAddressBits,
                ($urandom_range(99) < 70) ? $urandom_range(32, 16) : $urandom_range(63),
                AbitCfgW);
      write_reg(CfgHitTime, $urandom_range(255), HitTimeW);
      write_reg(CfgMissPenalty, $urandom_range(1023), PenaltyW);
      push_pace(pace_by_phase[phase % 3]);

      n_tags = $urandom_range(6, 2);
      n_sets = $urandom_range(3, 1);
      for (int k = 0; k < 6; k++) pool_tag[k] = $urandom;
      for (int k = 0; k < 3; k++) pool_set[k] = $urandom;

      for (int n = 0; n < 65; n++) begin
        // Hold the sender now and then until the unit has emptied out
        if ((phase == 0 && n == 37) || $urandom_range(99) < 3) push_drain();
        if ($urandom_range(99) < 85)
          push_lookup(compose_addr(pool_tag[$urandom_range(n_tags - 1)],
                                   pool_set[$urandom_range(n_sets - 1)]));
        else
          push_lookup($urandom);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until the plan is spent and every result is in, then let the tail
    // settle so a stray strobe still gets caught
    while (req_plan.size() != 0 || start || pending_lookups.size() != 0) @(posedge clk_i);
    repeat (2 * DrainHold) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS set_assoc_cache_tag_model_unit");
    end else begin
      $display("FAIL set_assoc_cache_tag_model_unit");
    end
    $finish;
  end

endmodule
